### hw/rtl/rrss_pkg.sv
// shared types, constants and control bundles for the round-robin sleep scheduler
package rrss_pkg;

	localparam int unsigned MAX_THREADS_DEF = 16;
	localparam int unsigned TID_W           = 8;
	localparam int unsigned TIME_W          = 32;
	localparam int unsigned WOKEN_W         = 5;

	localparam logic [TID_W-1:0]   IDLE_ID   = 8'd0;
	localparam logic [WOKEN_W-1:0] WOKEN_MAX = 5'd31;

	// operation codes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [TID_W-1:0]  thread_id;
		logic              goes_to_sleep;
		logic [TIME_W-1:0] wake_time;
		logic [TIME_W-1:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		logic [TID_W-1:0]   prev_thread;
		logic [TID_W-1:0]   next_thread;
		logic [WOKEN_W-1:0] woken_count;
	} out_item_t;

	typedef struct packed {
		logic [TID_W-1:0]  id;
		logic [TIME_W-1:0] wake;
	} sleep_entry_t;

	localparam int unsigned SLEEP_W = TID_W + TIME_W;

	typedef struct packed {
		logic capture;
		logic add_exec;
		logic tick_init;
		logic ring_rd;
		logic set_prev;
		logic set_next;
		logic ring_rotate;
		logic sleep_put;
		logic scan_start;
		logic scan_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic ring_empty;
		logic sleep_full;
		logic sleep_empty;
		logic goes_to_sleep;
		logic rd_is_idle;
		logic scan_last;
	} sts_t;

endpackage

### hw/rtl/rrss_ram.sv
// generic single-write, single-read ram with registered read data
module rrss_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/rrss_datapath.sv
// ready ring, sleep list, pointers and result registers of the scheduler
module rrss_datapath #(
	parameter int unsigned MAX_THREADS = rrss_pkg::MAX_THREADS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrss_pkg::in_item_t  req,
	input  rrss_pkg::cmd_t      cmd,
	output rrss_pkg::sts_t      sts,
	output rrss_pkg::out_item_t rsp
);

	localparam int unsigned AW = $clog2(MAX_THREADS);
	localparam int unsigned CW = $clog2(MAX_THREADS + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_THREADS);

	// circular index add, off never exceeds the depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(MAX_THREADS)) begin
			s = s - (CW+1)'(MAX_THREADS);
		end
		return AW'(s);
	endfunction

	logic [AW-1:0] ring_head_q, slp_head_q, scan_ptr_q;
	logic [CW-1:0] ring_cnt_q, slp_cnt_q, scan_left_q;
	logic          ring0_fresh_q, rd_fresh0_q;

	rrss_pkg::in_item_t  item_q;
	logic                acc_q;
	logic [7:0]          prev_q, next_q;
	logic [4:0]          woken_q;
	rrss_pkg::out_item_t rsp_q;

	logic                          ring_we, ring_re;
	logic [AW-1:0]                 ring_tail, ring_ra;
	logic [7:0]                    ring_wd, ring_rd_raw, ring_rd_eff;
	logic                          slp_we, slp_re;
	logic [AW-1:0]                 slp_tail, slp_ra;
	logic [rrss_pkg::SLEEP_W-1:0]  slp_wd, slp_rd_raw;
	rrss_pkg::sleep_entry_t        slp_rd;
	logic                          ring_full, due;

	assign ring_tail   = wrap_add(ring_head_q, ring_cnt_q);
	assign slp_tail    = wrap_add(slp_head_q, slp_cnt_q);
	assign ring_full   = (ring_cnt_q == FULL_CNT);
	// entry zero holds the idle id until first written
	assign ring_rd_eff = rd_fresh0_q ? rrss_pkg::IDLE_ID : ring_rd_raw;
	assign slp_rd      = rrss_pkg::sleep_entry_t'(slp_rd_raw);
	assign due         = (item_q.now_time >= slp_rd.wake) && !ring_full;

	always_comb begin
		ring_we = 1'b0;
		ring_wd = item_q.thread_id;
		if (cmd.add_exec && !ring_full) begin
			ring_we = 1'b1;
		end
		if (cmd.ring_rotate) begin
			ring_we = 1'b1;
			ring_wd = ring_rd_eff;
		end
		if (cmd.scan_step && due) begin
			ring_we = 1'b1;
			ring_wd = slp_rd.id;
		end
	end

	assign ring_re = cmd.ring_rd;
	assign ring_ra = ring_head_q;

	assign slp_we = cmd.sleep_put || (cmd.scan_step && !due);
	assign slp_wd = cmd.sleep_put ? {ring_rd_eff, item_q.wake_time} : slp_rd_raw;
	assign slp_re = cmd.scan_start || cmd.scan_step;
	assign slp_ra = cmd.scan_start ? slp_head_q : scan_ptr_q;

	rrss_ram #(
		.WIDTH(rrss_pkg::TID_W),
		.DEPTH(MAX_THREADS)
	) u_ring_ram (
		.clk    (clk),
		.wr_en  (ring_we),
		.wr_addr(ring_tail),
		.wr_data(ring_wd),
		.rd_en  (ring_re),
		.rd_addr(ring_ra),
		.rd_data(ring_rd_raw)
	);

	rrss_ram #(
		.WIDTH(rrss_pkg::SLEEP_W),
		.DEPTH(MAX_THREADS)
	) u_sleep_ram (
		.clk    (clk),
		.wr_en  (slp_we),
		.wr_addr(slp_tail),
		.wr_data(slp_wd),
		.rd_en  (slp_re),
		.rd_addr(slp_ra),
		.rd_data(slp_rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_head_q   <= '0;
			ring_cnt_q    <= CW'(1);
			slp_head_q    <= '0;
			slp_cnt_q     <= '0;
			scan_ptr_q    <= '0;
			scan_left_q   <= '0;
			ring0_fresh_q <= 1'b1;
			rd_fresh0_q   <= 1'b0;
		end else begin
			if (cmd.add_exec && !ring_full) begin
				ring_cnt_q <= ring_cnt_q + CW'(1);
			end
			if (cmd.ring_rotate) begin
				ring_head_q <= wrap_add(ring_head_q, CW'(1));
			end
			if (cmd.sleep_put) begin
				ring_head_q <= wrap_add(ring_head_q, CW'(1));
				ring_cnt_q  <= ring_cnt_q - CW'(1);
				slp_cnt_q   <= slp_cnt_q + CW'(1);
			end
			if (cmd.scan_start) begin
				scan_left_q <= slp_cnt_q;
				scan_ptr_q  <= wrap_add(slp_head_q, CW'(1));
			end
			if (cmd.scan_step) begin
				scan_left_q <= scan_left_q - CW'(1);
				scan_ptr_q  <= wrap_add(scan_ptr_q, CW'(1));
				slp_head_q  <= wrap_add(slp_head_q, CW'(1));
				if (due) begin
					ring_cnt_q <= ring_cnt_q + CW'(1);
					slp_cnt_q  <= slp_cnt_q - CW'(1);
				end
			end
			if (ring_we && (ring_tail == '0)) begin
				ring0_fresh_q <= 1'b0;
			end
			if (ring_re) begin
				rd_fresh0_q <= ring0_fresh_q && (ring_ra == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.add_exec) begin
			acc_q   <= !ring_full;
			prev_q  <= '0;
			next_q  <= '0;
			woken_q <= '0;
		end
		if (cmd.tick_init) begin
			acc_q   <= 1'b1;
			prev_q  <= rrss_pkg::IDLE_ID;
			next_q  <= rrss_pkg::IDLE_ID;
			woken_q <= '0;
		end
		if (cmd.set_prev) begin
			prev_q <= ring_rd_eff;
		end
		if (cmd.set_next) begin
			next_q <= ring_rd_eff;
		end
		if (cmd.scan_step && due && (woken_q != rrss_pkg::WOKEN_MAX)) begin
			woken_q <= woken_q + 5'd1;
		end
		if (cmd.load_out) begin
			rsp_q.accepted    <= acc_q;
			rsp_q.prev_thread <= prev_q;
			rsp_q.next_thread <= next_q;
			rsp_q.woken_count <= woken_q;
		end
	end

	assign rsp = rsp_q;

	assign sts.ring_empty    = (ring_cnt_q == '0);
	assign sts.sleep_full    = (slp_cnt_q == FULL_CNT);
	assign sts.sleep_empty   = (slp_cnt_q == '0);
	assign sts.goes_to_sleep = item_q.goes_to_sleep;
	assign sts.rd_is_idle    = (ring_rd_eff == rrss_pkg::IDLE_ID);
	assign sts.scan_last     = (scan_left_q == CW'(1));

endmodule

### hw/rtl/rrss_ctrl.sv
// sequencing state machine of the scheduler
module rrss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_op,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rrss_pkg::cmd_t cmd,
	input  rrss_pkg::sts_t sts
);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b00000000001,
		ST_ADD       = 11'b00000000010,
		ST_TICK_RD   = 11'b00000000100,
		ST_TICK_PREV = 11'b00000001000,
		ST_NEXT_RD   = 11'b00000010000,
		ST_NEXT_CHK  = 11'b00000100000,
		ST_NEXT2_RD  = 11'b00001000000,
		ST_NEXT2_GET = 11'b00010000000,
		ST_SCAN_RD   = 11'b00100000000,
		ST_SCAN      = 11'b01000000000,
		ST_DONE      = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = (req_op == rrss_pkg::OP_TICK) ? ST_TICK_RD : ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_exec = 1'b1;
				state_d = ST_DONE;
			end
			ST_TICK_RD: begin
				cmd.tick_init = 1'b1;
				if (sts.ring_empty) begin
					state_d = ST_SCAN_RD;
				end else begin
					cmd.ring_rd = 1'b1;
					state_d = ST_TICK_PREV;
				end
			end
			ST_TICK_PREV: begin
				cmd.set_prev = 1'b1;
				if (sts.goes_to_sleep && !sts.sleep_full) begin
					cmd.sleep_put = 1'b1;
				end else begin
					cmd.ring_rotate = 1'b1;
				end
				state_d = ST_NEXT_RD;
			end
			ST_NEXT_RD: begin
				if (sts.ring_empty) begin
					state_d = ST_SCAN_RD;
				end else begin
					cmd.ring_rd = 1'b1;
					state_d = ST_NEXT_CHK;
				end
			end
			ST_NEXT_CHK: begin
				if (sts.rd_is_idle) begin
					cmd.ring_rotate = 1'b1;
					state_d = ST_NEXT2_RD;
				end else begin
					cmd.set_next = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_NEXT2_RD: begin
				cmd.ring_rd = 1'b1;
				state_d = ST_NEXT2_GET;
			end
			ST_NEXT2_GET: begin
				cmd.set_next = 1'b1;
				state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				cmd.scan_start = 1'b1;
				state_d = sts.sleep_empty ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/round_robin_sleep_scheduler_unit.sv
// top level of the round-robin scheduler with sleep list
//
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | rrss_pkg::in_item_t
// rsp     | out       | rsp_valid / rsp_ready | rrss_pkg::out_item_t
//
// an add item appends to the ready ring when it is not full; a tick first works on the front
// of the ready ring, when it is not empty, and then scans each sleeper once through the sleep
// ram read port, so the sleep-list scan sets how the tick cost grows with the number of sleepers
// reset needs no clearing pass: ring entry zero reads as the idle id until first written
// one item is in work at a time; a finished result waits in the output register while the
// next item is taken, and a stalled rsp only holds the block once a second result is ready
module round_robin_sleep_scheduler_unit #(
	parameter int unsigned MAX_THREADS = rrss_pkg::MAX_THREADS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rrss_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rrss_pkg::out_item_t rsp
);

	// command and status bundles between sequencer and datapath
	rrss_pkg::cmd_t cmd;
	rrss_pkg::sts_t sts;

	// sequencer: walks front read, sleep or rotate, next pick, then the sleep scan
	rrss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_op   (req.operation),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: ready ring ram, sleep list ram, pointers and result registers
	rrss_datapath #(
		.MAX_THREADS(MAX_THREADS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule
